// ===== src/pcu_pkg.sv =====
// ----------------------------------------------------------------------------
// pcu_pkg
// Shared widths, configuration types, register indexes and the small
// lookup functions used by the port contention timing pipeline.
// ----------------------------------------------------------------------------
package pcu_pkg;

  localparam int ADDR_W     = 16;  // port address
  localparam int TS_W       = 20;  // incoming t-state count
  localparam int NT_W       = 21;  // outgoing t-state count
  localparam int FL_W       = 17;  // frame length, origin, reduced t-state
  localparam int LL_W       = 8;   // line length, display lines, line position
  localparam int ACC_W      = 6;   // added t-states
  localparam int FOLD_W     = 5;   // overshoot past one frame wrap
  localparam int BASE_W     = 3;   // base cycles of one step
  localparam int DLY_W      = 3;   // contention delay
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int SLOTS      = 4;   // steps per access

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_LENGTH   = 3'd0,
    CFG_DISPLAY_ORIGIN = 3'd1,
    CFG_LINE_LENGTH    = 3'd2,
    CFG_DISPLAY_LINES  = 3'd3,
    CFG_ALT_PATTERN    = 3'd4
  } cfg_reg_t;

  // Reset values of the registers
  localparam logic [FL_W-1:0] RST_FRAME_LENGTH   = 17'd69888;
  localparam logic [FL_W-1:0] RST_DISPLAY_ORIGIN = 17'd14335;
  localparam logic [LL_W-1:0] RST_LINE_LENGTH    = 8'd224;
  localparam logic [LL_W-1:0] RST_DISPLAY_LINES  = 8'd192;
  localparam logic            RST_ALT_PATTERN    = 1'b0;

  typedef struct packed {
    logic [FL_W-1:0] frame_length;
    logic [FL_W-1:0] display_origin;
    logic [LL_W-1:0] line_length;
    logic [LL_W-1:0] display_lines;
    logic            alternate_pattern;
  } cfg_t;

  // One access as it travels down the pipeline
  typedef struct packed {
    logic [TS_W-1:0]  start;
    logic             contended;
    logic             odd_port;
    logic [ACC_W-1:0] acc;
  } item_t;

  typedef struct packed {
    item_t           item;
    logic [FL_W-1:0] m0;     // start t-state modulo frame length
  } pkt_t;

  // Does this step of the access see a contention delay
  function automatic logic slot_contend(input logic contended, input logic odd_port,
                                        input logic [1:0] slot);
    logic r;
    r = 1'b0;
    case ({contended, odd_port})
      2'b00:   r = (slot == 2'd1);
      2'b01:   r = 1'b0;
      2'b10:   r = (slot <= 2'd1);
      2'b11:   r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Base cycles of this step of the access
  function automatic logic [BASE_W-1:0] slot_base(input logic contended, input logic odd_port,
                                                  input logic [1:0] slot);
    logic [BASE_W-1:0] r;
    r = '0;
    case ({contended, odd_port})
      2'b00, 2'b10: r = (slot == 2'd0) ? 3'd1 : ((slot == 2'd1) ? 3'd3 : 3'd0);
      2'b01:        r = (slot == 2'd0) ? 3'd4 : 3'd0;
      2'b11:        r = 3'd1;
      default:      r = '0;
    endcase
    return r;
  endfunction

  // Delay pattern indexed by line position mod 8
  function automatic logic [DLY_W-1:0] pattern_delay(input logic alt, input logic [2:0] idx);
    logic [DLY_W-1:0] r;
    if (alt) begin
      r = 3'd7 - idx;
    end else begin
      r = (idx >= 3'd6) ? 3'd0 : 3'd6 - idx;
    end
    return r;
  endfunction

endpackage

// ===== src/io_port_contention_timing_unit.sv =====
// ----------------------------------------------------------------------------
// io_port_contention_timing_unit
// Port access timing with ULA-style contention delays.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one port access: port_address,
//   high_byte_contended and current_tstate. Output channel (out_valid/
//   out_ready) returns added_tstates and new_tstate for each access, in order.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   by the user only while the block is idle; the block does not enforce it.
//   From input transfer to output valid, an access passes 20 stages of
//   remainder by the frame length, then four step units of 21 stages each
//   (frame fold, origin offset, one division bit per stage by the line
//   length, delay lookup), then the output register.
//   Throughput is one access per cycle while the receiver does not stall.
//   Reset clears every valid bit and loads the register defaults
//   (69888, 14335, 224, 192, 0).
//   When the receiver stalls, the whole pipeline holds and in_ready drops in
//   the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module io_port_contention_timing_unit #(
  parameter int CONTENDED_LINE_SPAN = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pcu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pcu_pkg::ADDR_W-1:0]      port_address,
  input  logic                            high_byte_contended,
  input  logic [pcu_pkg::TS_W-1:0]        current_tstate,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pcu_pkg::ACC_W-1:0]       added_tstates,
  output logic [pcu_pkg::NT_W-1:0]        new_tstate
);
  import pcu_pkg::*;

  cfg_t  cfg;
  logic  en;
  item_t in_item;
  logic  md_v;
  pkt_t  md_pkt;
  logic  chk_v   [SLOTS+1];
  pkt_t  chk_pkt [SLOTS+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_length      <= RST_FRAME_LENGTH;
      cfg.display_origin    <= RST_DISPLAY_ORIGIN;
      cfg.line_length       <= RST_LINE_LENGTH;
      cfg.display_lines     <= RST_DISPLAY_LINES;
      cfg.alternate_pattern <= RST_ALT_PATTERN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_LENGTH:   cfg.frame_length      <= cfg_data[FL_W-1:0];
        CFG_DISPLAY_ORIGIN: cfg.display_origin    <= cfg_data[FL_W-1:0];
        CFG_LINE_LENGTH:    cfg.line_length       <= cfg_data[LL_W-1:0];
        CFG_DISPLAY_LINES:  cfg.display_lines     <= cfg_data[LL_W-1:0];
        CFG_ALT_PATTERN:    cfg.alternate_pattern <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline whenever the output register is free or drains
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign in_item.start     = current_tstate;
  assign in_item.contended = high_byte_contended;
  assign in_item.odd_port  = port_address[0];
  assign in_item.acc       = '0;

  pcu_mod_div u_mod_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_valid (md_v),
    .out_pkt   (md_pkt)
  );

  assign chk_v[0]   = md_v;
  assign chk_pkt[0] = md_pkt;

  genvar k;
  generate
    for (k = 0; k < SLOTS; k++) begin : g_step
      pcu_check #(
        .SLOT (k),
        .SPAN (CONTENDED_LINE_SPAN)
      ) u_check (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (chk_v[k]),
        .in_pkt    (chk_pkt[k]),
        .out_valid (chk_v[k+1]),
        .out_pkt   (chk_pkt[k+1])
      );
    end
  endgenerate

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chk_v[SLOTS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      added_tstates <= chk_pkt[SLOTS].item.acc;
      new_tstate    <= (NT_W)'(chk_pkt[SLOTS].item.start)
                       + (NT_W)'(chk_pkt[SLOTS].item.acc);
    end
  end

`ifndef SYNTHESIS
  // Every access costs at least its four base cycles and at most 32
  a_added_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (added_tstates >= 6'd4 && added_tstates <= 6'd32))
    else $error("added t-states out of range");

  // Without a contended area only base cycles are added
  a_no_contention: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (cfg.frame_length == '0 || cfg.line_length == '0
                   || cfg.display_lines == '0)) |-> added_tstates == 6'd4)
    else $error("contention added outside any display area");

  // A held output keeps the pipeline frozen behind it
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(chk_v[SLOTS]) && $stable(chk_pkt[SLOTS]))
    else $error("pipeline moved during a stall");
`endif

endmodule

// ===== src/pcu_mod_div.sv =====
// ----------------------------------------------------------------------------
// pcu_mod_div
// Pipelined restoring remainder: start t-state modulo frame length, one
// dividend bit per stage.
// ----------------------------------------------------------------------------
module pcu_mod_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  pcu_pkg::cfg_t cfg,
  input  logic          in_valid,
  input  pcu_pkg::item_t in_item,
  output logic          out_valid,
  output pcu_pkg::pkt_t out_pkt
);
  import pcu_pkg::*;

  logic [TS_W-1:0] v;
  item_t           it  [TS_W];
  logic [FL_W-1:0] rem [TS_W];

  genvar s;
  generate
    for (s = 0; s < TS_W; s++) begin : g_stage
      logic            prev_v;
      item_t           prev_it;
      logic [FL_W-1:0] prev_rem;
      logic [FL_W:0]   shifted;
      logic [FL_W:0]   diff;

      if (s == 0) begin : g_first
        assign prev_v   = in_valid;
        assign prev_it  = in_item;
        assign prev_rem = '0;
      end else begin : g_next
        assign prev_v   = v[s-1];
        assign prev_it  = it[s-1];
        assign prev_rem = rem[s-1];
      end

      // shift in one dividend bit, subtract the divisor when it fits
      assign shifted = {prev_rem, prev_it.start[TS_W-1-s]};
      assign diff    = shifted - {1'b0, cfg.frame_length};

      always_ff @(posedge clk) begin
        if (rst) begin
          v[s] <= 1'b0;
        end else if (en) begin
          v[s] <= prev_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          it[s]  <= prev_it;
          rem[s] <= (shifted >= {1'b0, cfg.frame_length}) ? diff[FL_W-1:0]
                                                          : shifted[FL_W-1:0];
        end
      end
    end
  endgenerate

  assign out_valid    = v[TS_W-1];
  assign out_pkt.item = it[TS_W-1];
  assign out_pkt.m0   = rem[TS_W-1];

endmodule

// ===== src/pcu_check.sv =====
// ----------------------------------------------------------------------------
// pcu_check
// One step of an access: locate the current t-state in the frame, divide
// by the line length, look up the delay and add delay plus base cycles.
// ----------------------------------------------------------------------------
module pcu_check #(
  parameter int SLOT = 0,
  parameter int SPAN = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  pcu_pkg::cfg_t cfg,
  input  logic          in_valid,
  input  pcu_pkg::pkt_t in_pkt,
  output logic          out_valid,
  output pcu_pkg::pkt_t out_pkt
);
  import pcu_pkg::*;

  localparam logic [1:0]  SLOT_ID  = 2'(SLOT);
  localparam logic [LL_W:0] SPAN_LIM = (LL_W+1)'(SPAN);

  typedef struct packed {
    pkt_t            pkt;
    logic            under;
    logic [FL_W-1:0] rel;
    logic [FL_W-1:0] quo;
    logic [LL_W-1:0] rem;
  } div_t;

  // Stage A: add the accumulated t-states and fold once past the frame
  logic [FL_W:0]     x_sum;
  logic [FL_W:0]     x_wrap;
  logic              wrap;
  logic              a_v;
  pkt_t              a_pkt;
  logic [FL_W-1:0]   a_x;
  logic [FOLD_W-1:0] a_y;
  logic              a_fold;

  assign x_sum  = {1'b0, in_pkt.m0} + (FL_W+1)'(in_pkt.item.acc);
  assign wrap   = x_sum >= {1'b0, cfg.frame_length};
  assign x_wrap = x_sum - {1'b0, cfg.frame_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pkt  <= in_pkt;
      a_x    <= wrap ? x_wrap[FL_W-1:0] : x_sum[FL_W-1:0];
      a_y    <= x_wrap[FOLD_W-1:0];
      a_fold <= wrap && (x_wrap >= {1'b0, cfg.frame_length});
    end
  end

  // Stage B: finish the modulo for very short frames
  logic [FOLD_W:0]   fr;
  logic [FL_W-1:0]   m_next;
  logic              b_v;
  pkt_t              b_pkt;
  logic [FL_W-1:0]   b_m;

  always_comb begin
    fr = '0;
    for (int i = FOLD_W - 1; i >= 0; i--) begin
      fr = {fr[FOLD_W-1:0], a_y[i]};
      if ((FL_W)'(fr) >= cfg.frame_length) begin
        fr = (FOLD_W+1)'((FL_W)'(fr) - cfg.frame_length);
      end
    end
    m_next = a_fold ? (FL_W)'(fr) : a_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pkt <= a_pkt;
      b_m   <= m_next;
    end
  end

  // Stage C: offset from the display origin
  logic c_v;
  div_t c_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_d.pkt   <= b_pkt;
      c_d.under <= b_m < cfg.display_origin;
      c_d.rel   <= b_m - cfg.display_origin;
      c_d.quo   <= '0;
      c_d.rem   <= '0;
    end
  end

  // Stages D: restoring division of the offset by the line length
  logic [FL_W-1:0] dv;
  div_t            dd [FL_W];

  genvar d;
  generate
    for (d = 0; d < FL_W; d++) begin : g_div
      logic          prev_v;
      div_t          prev_d;
      logic [LL_W:0] shifted;
      logic [LL_W:0] diff;
      logic          ge;

      if (d == 0) begin : g_first
        assign prev_v = c_v;
        assign prev_d = c_d;
      end else begin : g_next
        assign prev_v = dv[d-1];
        assign prev_d = dd[d-1];
      end

      assign shifted = {prev_d.rem, prev_d.rel[FL_W-1-d]};
      assign diff    = shifted - {1'b0, cfg.line_length};
      assign ge      = shifted >= {1'b0, cfg.line_length};

      always_ff @(posedge clk) begin
        if (rst) begin
          dv[d] <= 1'b0;
        end else if (en) begin
          dv[d] <= prev_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dd[d].pkt   <= prev_d.pkt;
          dd[d].under <= prev_d.under;
          dd[d].rel   <= prev_d.rel;
          dd[d].quo   <= {prev_d.quo[FL_W-2:0], ge};
          dd[d].rem   <= ge ? diff[LL_W-1:0] : shifted[LL_W-1:0];
        end
      end
    end
  endgenerate

  // Stage E: delay lookup and accumulate
  div_t              fin;
  logic              hit;
  logic [DLY_W-1:0]  delay;
  logic [BASE_W-1:0] base;
  logic              e_v;
  pkt_t              e_pkt;
  pkt_t              e_pkt_next;

  assign fin = dd[FL_W-1];
  assign hit = !fin.under && (cfg.frame_length != '0) && (cfg.line_length != '0)
               && (fin.quo < (FL_W)'(cfg.display_lines))
               && ({1'b0, fin.rem} < SPAN_LIM)
               && slot_contend(fin.pkt.item.contended, fin.pkt.item.odd_port, SLOT_ID);
  assign delay = hit ? pattern_delay(cfg.alternate_pattern, fin.rem[2:0]) : '0;
  assign base  = slot_base(fin.pkt.item.contended, fin.pkt.item.odd_port, SLOT_ID);

  always_comb begin
    e_pkt_next          = fin.pkt;
    e_pkt_next.item.acc = fin.pkt.item.acc + (ACC_W)'(delay) + (ACC_W)'(base);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= dv[FL_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_pkt <= e_pkt_next;
    end
  end

  assign out_valid = e_v;
  assign out_pkt   = e_pkt;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Port contention timing testbench: drives port accesses through the
// valid/ready input, predicts the access cost from the current register
// settings and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import pcu_pkg::*;

  localparam int LATENCY   = 105;
  localparam int MAX_CYC   = 3000000;
  localparam int SPAN      = 128;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [ADDR_W-1:0]     port_address;
  logic                  high_byte_contended;
  logic [TS_W-1:0]       current_tstate;
  logic                  out_valid;
  logic                  out_ready;
  logic [ACC_W-1:0]      added_tstates;
  logic [NT_W-1:0]       new_tstate;

  typedef struct {
    logic [ACC_W-1:0] added;
    logic [NT_W-1:0]  tstate;
  } cost_t;

  cost_t expected_costs[$];
  cfg_t  timing_cfg;
  int    mismatches;
  int    cycles;
  bit    hold_receiver;
  bit    quiet_receiver;
  int    long_hold;

  io_port_contention_timing_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .port_address(port_address),
    .high_byte_contended(high_byte_contended), .current_tstate(current_tstate),
    .out_valid(out_valid), .out_ready(out_ready), .added_tstates(added_tstates),
    .new_tstate(new_tstate)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Delay seen at one t-state under the current settings
  function automatic int unsigned contention_delay(int unsigned t);
    int unsigned m;
    int unsigned rel;
    int unsigned pos;
    if (timing_cfg.frame_length == 0 || timing_cfg.line_length == 0) return 0;
    m = t % timing_cfg.frame_length;
    if (m < timing_cfg.display_origin) return 0;
    rel = m - timing_cfg.display_origin;
    pos = rel % timing_cfg.line_length;
    if (rel / timing_cfg.line_length < timing_cfg.display_lines && pos < SPAN) begin
      if (timing_cfg.alternate_pattern) return 7 - (pos & 7);
      return ((pos & 7) >= 6) ? 0 : 6 - (pos & 7);
    end
    return 0;
  endfunction

  // Walk the access steps and return its cost
  function automatic cost_t access_cost(logic [ADDR_W-1:0] addr, logic cont,
                                        logic [TS_W-1:0] start);
    int unsigned t;
    cost_t c;
    t = 32'(start);
    if (cont && !addr[0]) begin
      t += contention_delay(t) + 1;
      t += contention_delay(t) + 3;
    end else if (cont) begin
      repeat (4) t += contention_delay(t) + 1;
    end else if (!addr[0]) begin
      t += 1;
      t += contention_delay(t) + 3;
    end else begin
      t += 4;
    end
    c.added  = ACC_W'(t - start);
    c.tstate = NT_W'(t);
    return c;
  endfunction

  // Random gap: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_access(logic [ADDR_W-1:0] addr, logic cont, logic [TS_W-1:0] ts);
    expected_costs.push_back(access_cost(addr, cont, ts));
    in_valid            <= 1'b1;
    port_address        <= addr;
    high_byte_contended <= cont;
    current_tstate      <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet_receiver) repeat (gap_len()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic finish_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for the pipeline to drain, then let in-flight work settle
  task automatic drain();
    finish_stream();
    while (expected_costs.size() != 0 && cycles < MAX_CYC) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      CFG_FRAME_LENGTH:   timing_cfg.frame_length      = FL_W'(val);
      CFG_DISPLAY_ORIGIN: timing_cfg.display_origin    = FL_W'(val);
      CFG_LINE_LENGTH:    timing_cfg.line_length       = LL_W'(val);
      CFG_DISPLAY_LINES:  timing_cfg.display_lines     = LL_W'(val);
      CFG_ALT_PATTERN:    timing_cfg.alternate_pattern = val[0];
      default: ;
    endcase
  endtask

  task automatic set_timing(int unsigned fl, int unsigned org, int unsigned ll,
                            int unsigned dl, int unsigned alt);
    write_reg(CFG_FRAME_LENGTH, fl);
    write_reg(CFG_DISPLAY_ORIGIN, org);
    write_reg(CFG_LINE_LENGTH, ll);
    write_reg(CFG_DISPLAY_LINES, dl);
    write_reg(CFG_ALT_PATTERN, alt);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // T-state biased toward the contended area of a randomly chosen frame
  function automatic logic [TS_W-1:0] pick_tstate();
    int unsigned frames;
    int unsigned off;
    if ($urandom_range(0, 3) == 0) return TS_W'($urandom());
    frames = $urandom_range(0, 14);
    off = timing_cfg.display_origin + $urandom_range(0, 300) +
          timing_cfg.line_length * $urandom_range(0, timing_cfg.display_lines);
    if ($urandom_range(0, 5) == 0) off = $urandom_range(0, timing_cfg.display_origin);
    return TS_W'(frames * timing_cfg.frame_length + off);
  endfunction

  task automatic test_directed();
    logic [ADDR_W-1:0] addrs[4] = '{16'h0000, 16'hFFFF, 16'hFFFE, 16'h0001};
    for (int i = 0; i < 4; i++) begin
      send_access(addrs[i], 1'b0, 20'd14335);
      send_access(addrs[i], 1'b1, 20'd14335);
      send_access(addrs[i], 1'b1, 20'd14340);
    end
    send_access(16'hFE, 1'b1, 20'hFFFFF);
    send_access(16'hFF, 1'b1, 20'hFFFFF);
    send_access(16'hFE, 1'b1, 20'd0);
    send_access(16'hFE, 1'b1, 20'd14334);
    send_access(16'hAAAA, 1'b1, TS_W'(14335 + 224 * 191 + 127));
    send_access(16'h5555, 1'b1, TS_W'(14335 + 224 * 192));
    drain();
  endtask

  task automatic test_special_settings();
    // zero frame length, zero line length, origin past the frame, extremes
    set_timing(0, 0, 224, 192, 0);
    repeat (6) send_access(ADDR_W'($urandom()), 1'b1, TS_W'($urandom()));
    drain();
    set_timing(69888, 0, 0, 192, 1);
    repeat (6) send_access(ADDR_W'($urandom()), 1'b1, TS_W'($urandom()));
    drain();
    set_timing(1000, 5000, 16, 255, 0);
    repeat (6) send_access(ADDR_W'($urandom()), 1'b1, TS_W'($urandom()));
    drain();
    set_timing(131071, 131071, 255, 255, 1);
    repeat (6) send_access(ADDR_W'($urandom()), 1'b1, TS_W'($urandom()));
    drain();
    set_timing(1, 0, 1, 0, 0);
    repeat (6) send_access(ADDR_W'($urandom()), 1'b1, TS_W'($urandom()));
    drain();
  endtask

  task automatic test_random(int n);
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_timing(69888, 14335, 224, 192, 0);
        1: set_timing(70908, 14361, 228, 192, 1);
        2: set_timing($urandom_range(1, 131071), $urandom_range(0, 3000),
                      $urandom_range(1, 255), $urandom_range(0, 255), $urandom_range(0, 1));
        3: set_timing(4000, 10, 8, 255, 1);
        4: set_timing(131071, 0, 255, 255, 0);
        default: set_timing($urandom_range(200, 9000), $urandom_range(0, 200),
                            $urandom_range(1, 40), $urandom_range(1, 255), 1);
      endcase
      repeat (n / 6)
        send_access(ADDR_W'($urandom()), 1'($urandom()), pick_tstate());
      drain();
    end
  endtask

  // Hold the receiver off long enough to fill the pipeline
  task automatic test_backpressure();
    quiet_receiver = 1'b1;
    hold_receiver  = 1'b1;
    long_hold      = 400;
    repeat (250) send_access(ADDR_W'($urandom()), 1'($urandom()), pick_tstate());
    quiet_receiver = 1'b0;
    drain();
  endtask

  // Receiver: random stalls, plus a counted long hold on request
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        hold_receiver = 1'b0;
      end else if (quiet_receiver || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_costs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: added=%0d tstate=%0d",
                                       added_tstates, new_tstate);
      end else begin
        cost_t e;
        e = expected_costs.pop_front();
        if (e.added !== added_tstates || e.tstate !== new_tstate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: added exp %0d got %0d, tstate exp %0d got %0d",
                     e.added, added_tstates, e.tstate, new_tstate);
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYC) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_LENGTH;
    cfg_data = '0;
    in_valid = 1'b0;
    port_address = '0;
    high_byte_contended = 1'b0;
    current_tstate = '0;
    mismatches = 0;
    cycles = 0;
    hold_receiver = 1'b0;
    quiet_receiver = 1'b0;
    long_hold = 0;
    timing_cfg.frame_length      = RST_FRAME_LENGTH;
    timing_cfg.display_origin    = RST_DISPLAY_ORIGIN;
    timing_cfg.line_length       = RST_LINE_LENGTH;
    timing_cfg.display_lines     = RST_DISPLAY_LINES;
    timing_cfg.alternate_pattern = RST_ALT_PATTERN;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_special_settings();
    test_backpressure();
    test_random(1320);
    if (mismatches == 0 && expected_costs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pcu_pkg.sv
src/pcu_mod_div.sv
src/pcu_check.sv
src/io_port_contention_timing_unit.sv
tb/sv/tb_top.sv
